/* hw/rtl/cle_pkg.sv */
`timescale 1ns / 1ps

package cle_pkg;

   // ring geometry
   localparam int BUFFER_DEPTH = 128;
   localparam int IDX_MOD      = 2 * BUFFER_DEPTH;
   localparam int IDX_W        = $clog2(IDX_MOD);
   localparam int SLOT_W       = $clog2(BUFFER_DEPTH);

   // field widths
   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 8;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam idx_type DEPTH_IDX = IDX_W'(BUFFER_DEPTH);
   localparam idx_type LAST_IDX  = IDX_W'(IDX_MOD - 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEND  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ERASE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EOF   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DUMP  = 3'd6;

   // control characters
   localparam byte_type CHAR_NUL  = 8'h00;
   localparam byte_type CHAR_CTLD = 8'h04;
   localparam byte_type CHAR_CTLH = 8'h08;
   localparam byte_type CHAR_NL   = 8'h0A;
   localparam byte_type CHAR_CR   = 8'h0D;
   localparam byte_type CHAR_CTLP = 8'h10;
   localparam byte_type CHAR_CTLU = 8'h15;
   localparam byte_type CHAR_DEL  = 8'h7F;

   typedef struct packed {
      logic [OP_W-1:0] op;
      byte_type        data;
      logic            first_of_read;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      byte_type           byte_out;
      logic [COUNT_W-1:0] erase_count;
      logic               line_ready;
      logic               end_of_line;
   } rsp_payload_type;

   // index arithmetic modulo twice the depth
   function automatic idx_type idx_inc(input idx_type i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   function automatic idx_type idx_dist(input idx_type a, input idx_type b);
      logic [IDX_W:0] wrapped;
      wrapped = {1'b0, a} + (IDX_W + 1)'(IDX_MOD) - {1'b0, b};
      return (a >= b) ? a - b : wrapped[IDX_W-1:0];
   endfunction

   function automatic slot_type idx_slot(input idx_type i);
      idx_type folded;
      folded = (i >= DEPTH_IDX) ? i - DEPTH_IDX : i;
      return folded[SLOT_W-1:0];
   endfunction

endpackage

/* hw/rtl/cle_req_if.sv */
`timescale 1ns / 1ps

interface cle_req_if;
   import cle_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/cle_rsp_if.sv */
`timescale 1ns / 1ps

interface cle_rsp_if;
   import cle_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/console_line_editor_top.sv */
`timescale 1ns / 1ps

// channel    dir  payload                                       beat when
// req_chan   in   op, data, first_of_read                       valid & ready
// rsp_chan   out  kind, byte_out, erase_count, line_ready, eol  valid & ready
//
// one result beat per request beat; keyboard, write and empty reads go straight to
// the result register, a read of a stored byte first passes the line store's
// registered read port. a new request is taken in the cycle the result drains.
// reset clears the three ring indices and the handshake state; the line store
// needs no clearing since only written entries are ever read.
// a stalled result holds the request side off until it is taken.

module console_line_editor_top (
   input  logic      clock,
   input  logic      reset,
   cle_req_if.sink   req_chan,
   cle_rsp_if.source rsp_chan
);
   import cle_pkg::*;

   typedef enum logic {ST_IDLE, ST_FETCH} state_type;

   state_type       state_ff, state_in;
   idx_type         read_ff, read_in;
   idx_type         commit_ff, commit_in;
   idx_type         edit_ff, edit_in;
   logic            first_ff, first_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   byte_type        line_store [BUFFER_DEPTH];
   byte_type        mem_rd_ff;
   logic            wr_en;
   slot_type        wr_slot;
   byte_type        wr_data;

   logic            req_accept;
   req_payload_type req;

   assign req = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // next state of indices and result
   always_comb begin
      rsp_payload_type res;
      byte_type        ch;
      idx_type         pending;
      idx_type         edit_next;

      res          = '0;
      ch           = req.data;
      pending      = idx_dist(edit_ff, commit_ff);
      edit_next    = idx_inc(edit_ff);
      state_in     = state_ff;
      read_in      = read_ff;
      commit_in    = commit_ff;
      edit_in      = edit_ff;
      first_in     = first_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_slot      = idx_slot(edit_ff);
      wr_data      = ch;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req.op)
                  OP_KEY: begin
                     priority if (ch == CHAR_CTLP) begin
                        res.kind = KIND_DUMP;
                     end else if (ch == CHAR_CTLU) begin
                        if (pending != '0) begin
                           res.kind        = KIND_ERASE;
                           res.erase_count = COUNT_W'(pending);
                           edit_in         = commit_ff;
                        end
                     end else if (ch == CHAR_CTLH || ch == CHAR_DEL) begin
                        if (edit_ff != commit_ff) begin
                           res.kind        = KIND_ERASE;
                           res.erase_count = COUNT_W'(1);
                           edit_in         = idx_dec(edit_ff);
                        end
                     end else if (ch != CHAR_NUL &&
                                  idx_dist(edit_ff, read_ff) < DEPTH_IDX) begin
                        if (ch == CHAR_CR) begin
                           ch = CHAR_NL;
                        end
                        wr_en        = 1'b1;
                        wr_data      = ch;
                        edit_in      = edit_next;
                        res.kind     = KIND_SEND;
                        res.byte_out = ch;
                        if (ch == CHAR_NL || ch == CHAR_CTLD ||
                            idx_dist(edit_next, read_ff) == DEPTH_IDX) begin
                           commit_in      = edit_next;
                           res.line_ready = 1'b1;
                        end
                     end else begin
                        res.kind = KIND_NONE;
                     end
                     rsp_in       = res;
                     rsp_valid_in = 1'b1;
                  end
                  OP_READ: begin
                     if (read_ff == commit_ff) begin
                        res.kind     = KIND_EMPTY;
                        rsp_in       = res;
                        rsp_valid_in = 1'b1;
                     end else begin
                        // byte arrives from the store next cycle
                        state_in     = ST_FETCH;
                        first_in     = req.first_of_read;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  OP_WRITE: begin
                     res.kind     = KIND_SEND;
                     res.byte_out = req.data;
                     rsp_in       = res;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_in       = res;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // end of file stays in the ring unless it opens a read
            if (mem_rd_ff == CHAR_CTLD) begin
               res.kind = KIND_EOF;
               if (first_ff) begin
                  read_in = idx_inc(read_ff);
               end
            end else begin
               res.kind        = KIND_READ;
               res.byte_out    = mem_rd_ff;
               res.end_of_line = (mem_rd_ff == CHAR_NL);
               read_in         = idx_inc(read_ff);
            end
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, indices and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // line store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[wr_slot] <= wr_data;
      end
      mem_rd_ff <= line_store[idx_slot(read_ff)];
   end

`ifndef SYNTH
   // pending bytes never exceed the ring, committed never past edited
   assert property (@(posedge clock) disable iff (reset)
      (idx_dist(edit_ff, read_ff) <= DEPTH_IDX) &&
      (idx_dist(commit_ff, read_ff) <= idx_dist(edit_ff, read_ff)))
      else $error("ring indices out of order");

   // a read of a stored byte passes through the fetch state before its result is valid
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req.op == OP_READ && read_ff != commit_ff)
      |=> (!rsp_valid_ff && state_ff == ST_FETCH) ##1 rsp_valid_ff)
      else $error("read fetch did not produce a result");

   // an erase result always names at least one character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERASE) |-> (rsp_ff.erase_count != '0))
      else $error("erase with zero count");

   // indices only move on an accepted request or the fetch cycle
   assert property (@(posedge clock) disable iff (reset)
      (!req_accept && state_ff == ST_IDLE)
      |=> ($stable(read_ff) && $stable(commit_ff) && $stable(edit_ff)))
      else $error("index moved without a request");
`endif

endmodule

/* tb/line_editor_checker.sv */
`timescale 1ns / 1ps

module line_editor_checker (
   input  logic clock,
   input  logic reset,
   cle_req_if   req_mon,
   cle_rsp_if   rsp_mon,
   output int   mismatches,
   output int   awaiting,
   output int   lines_done,
   output int   reads_done,
   output int   eofs_done,
   output int   full_hits
);
   import cle_pkg::*;

   localparam int RING_SPAN = 2 * BUFFER_DEPTH;

   // own copy of the ring and its three positions
   byte_type line_copy [BUFFER_DEPTH];
   int       read_pos;
   int       commit_pos;
   int       edit_pos;

   // results still owed by the block, oldest first
   rsp_payload_type due_results [$];

   function automatic int ring_gap(input int a, input int b);
      return (a + RING_SPAN - b) % RING_SPAN;
   endfunction

   // apply one request beat to the ring copy and work out its result
   function automatic rsp_payload_type edit_and_predict(input req_payload_type r);
      rsp_payload_type res;
      byte_type        ch;
      byte_type        held;
      int              span;
      res = '0;
      ch  = r.data;
      case (r.op)
         OP_KEY: begin
            if (ch == CHAR_CTLP) begin
               res.kind = KIND_DUMP;
            end else if (ch == CHAR_CTLU) begin
               // uncommitted bytes carry no newline, so the kill is one count
               span = ring_gap(edit_pos, commit_pos);
               if (span != 0) begin
                  res.kind        = KIND_ERASE;
                  res.erase_count = COUNT_W'(span);
                  edit_pos        = commit_pos;
               end
            end else if (ch == CHAR_CTLH || ch == CHAR_DEL) begin
               if (edit_pos != commit_pos) begin
                  edit_pos        = (edit_pos + RING_SPAN - 1) % RING_SPAN;
                  res.kind        = KIND_ERASE;
                  res.erase_count = COUNT_W'(1);
               end
            end else if (ch != CHAR_NUL) begin
               if (ring_gap(edit_pos, read_pos) >= BUFFER_DEPTH) begin
                  // ring full: the byte is dropped
                  full_hits++;
               end else begin
                  if (ch == CHAR_CR) ch = CHAR_NL;
                  line_copy[edit_pos % BUFFER_DEPTH] = ch;
                  edit_pos     = (edit_pos + 1) % RING_SPAN;
                  res.kind     = KIND_SEND;
                  res.byte_out = ch;
                  if (ring_gap(edit_pos, read_pos) == BUFFER_DEPTH) full_hits++;
                  if (ch == CHAR_NL || ch == CHAR_CTLD ||
                      ring_gap(edit_pos, read_pos) == BUFFER_DEPTH) begin
                     commit_pos     = edit_pos;
                     res.line_ready = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            if (read_pos == commit_pos) begin
               res.kind = KIND_EMPTY;
            end else begin
               held = line_copy[read_pos % BUFFER_DEPTH];
               if (held == CHAR_CTLD) begin
                  // end of file is only consumed at the start of a read
                  if (r.first_of_read) read_pos = (read_pos + 1) % RING_SPAN;
                  res.kind = KIND_EOF;
               end else begin
                  read_pos        = (read_pos + 1) % RING_SPAN;
                  res.kind        = KIND_READ;
                  res.byte_out    = held;
                  res.end_of_line = (held == CHAR_NL);
               end
            end
         end
         OP_WRITE: begin
            res.kind     = KIND_SEND;
            res.byte_out = ch;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report(input string field, input int got, input int want);
      $display("mismatch at %0t: %s is %0d, predicted %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   // watch both channels on every rising edge
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         read_pos   = 0;
         commit_pos = 0;
         edit_pos   = 0;
         due_results.delete();
         mismatches = 0;
         awaiting   = 0;
         lines_done = 0;
         reads_done = 0;
         eofs_done  = 0;
         full_hits  = 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (due_results.size() == 0) begin
               report("unrequested result kind", got.kind, -1);
            end else begin
               want = due_results.pop_front();
               if (got.kind != want.kind) report("kind", got.kind, want.kind);
               if (got.byte_out != want.byte_out)
                  report("byte_out", got.byte_out, want.byte_out);
               if (got.erase_count != want.erase_count)
                  report("erase_count", got.erase_count, want.erase_count);
               if (got.line_ready != want.line_ready)
                  report("line_ready", got.line_ready, want.line_ready);
               if (got.end_of_line != want.end_of_line)
                  report("end_of_line", got.end_of_line, want.end_of_line);
            end
         end
         // request beat
         if (req_mon.valid && req_mon.ready) begin
            want = edit_and_predict(req_mon.payload);
            due_results.push_back(want);
            if (want.line_ready) lines_done++;
            if (want.kind == KIND_READ) reads_done++;
            if (want.kind == KIND_EOF) eofs_done++;
         end
         awaiting = due_results.size();
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import cle_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TARGET_ITEMS = 650;
   localparam int QUIET_FROM   = 560;
   localparam int HOLD_CYCLES  = 90;
   localparam int FILL_LENGTH  = 136;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;

   cle_req_if req_chan ();
   cle_rsp_if rsp_chan ();

   int mismatches;
   int awaiting;
   int lines_done;
   int reads_done;
   int eofs_done;
   int full_hits;

   int   useful_sent;
   int   cycle_count;
   logic tx_idle_on;
   logic rx_idle_on;
   logic quiet;
   logic hold_go;
   logic hold_active;

   console_line_editor_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   line_editor_checker line_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .lines_done (lines_done),
      .reads_done (reads_done),
      .eofs_done  (eofs_done),
      .full_hits  (full_hits)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  awaiting);
         $display("testbench failed");
         $finish;
      end
   end

   // long receiver hold so the block backs up into the request side
   initial begin
      hold_active = 1'b0;
      wait (hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_active = 1'b0;
   end

   // result side ready, with random stall bursts
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || hold_active) begin
            rsp_chan.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else if (rx_idle_on && !quiet && $urandom_range(0, 6) == 0) begin
            rsp_chan.ready = 1'b0;
            stall_left     = $urandom_range(0, 16);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // one request beat, with an occasional gap in front of it
   task automatic push_req(input logic [OP_W-1:0] op, input byte_type data,
                           input logic first);
      if (tx_idle_on && !quiet && $urandom_range(0, 6) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_chan.valid                 = 1'b1;
      req_chan.payload.op            = op;
      req_chan.payload.data          = data;
      req_chan.payload.first_of_read = first;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (op != OP_UNUSED && !(op == OP_KEY && data == CHAR_NUL)) useful_sent++;
   endtask

   task automatic key(input byte_type data);
      push_req(OP_KEY, data, 1'($urandom_range(0, 1)));
   endtask

   task automatic rd(input logic first);
      push_req(OP_READ, byte_type'($urandom_range(0, 255)), first);
   endtask

   // keyboard byte for a typed line: mostly text, some editing keys
   function automatic byte_type line_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return byte_type'($urandom_range(8'h20, 8'h7E));
      if (pick < 78) return byte_type'($urandom_range(0, 255));
      if (pick < 81) return CHAR_CTLH;
      if (pick < 84) return CHAR_DEL;
      if (pick < 86) return CHAR_CTLU;
      if (pick < 88) return CHAR_CTLP;
      if (pick < 90) return CHAR_NUL;
      if (pick < 95) return CHAR_CR;
      return CHAR_NL;
   endfunction

   initial begin
      int  pick;
      int  count;
      logic fill_done;
      reset                          = 1'b1;
      req_chan.valid                 = 1'b0;
      req_chan.payload               = '0;
      useful_sent                    = 0;
      tx_idle_on                     = 1'b1;
      rx_idle_on                     = 1'b1;
      quiet                          = 1'b0;
      hold_go                        = 1'b0;
      fill_done                      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty ring, ignored and idle keys, dump request
      rd(1'b1);
      key(CHAR_NUL);
      key(CHAR_CTLP);
      key(CHAR_CTLH);
      key(CHAR_DEL);
      key(CHAR_CTLU);
      // single erases and a whole-line kill
      key(8'h61);
      key(8'hFF);
      key(CHAR_CTLH);
      key(CHAR_DEL);
      key(8'h78);
      key(8'h80);
      key(CHAR_CTLU);
      // carriage return commits as newline, then read the line back
      key(8'h68);
      key(CHAR_CR);
      rd(1'b1);
      rd(1'b0);
      // end of file kept mid-read, consumed at the start of one
      key(CHAR_CTLD);
      rd(1'b0);
      rd(1'b1);
      rd(1'b0);
      // unknown op and terminal writes at the byte extremes
      push_req(OP_UNUSED, 8'hFF, 1'b1);
      push_req(OP_WRITE, 8'hFF, 1'b0);
      push_req(OP_WRITE, 8'h00, 1'b1);

      // random traffic in short scenarios
      useful_sent = 0;
      while (useful_sent < TARGET_ITEMS) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if (useful_sent >= QUIET_FROM) quiet = 1'b1;
         if (useful_sent >= 120) hold_go = 1'b1;
         pick = $urandom_range(0, 99);
         if (!fill_done && useful_sent >= 260) pick = 99;
         if (pick < 45) begin
            // typed line ending in newline, return or end of file
            count = $urandom_range(0, 12);
            repeat (count) key(line_byte());
            pick = $urandom_range(0, 4);
            key((pick == 0) ? CHAR_CTLD : (pick < 3) ? CHAR_CR : CHAR_NL);
         end else if (pick < 75) begin
            // read burst, first byte flagged as the start of a read
            count = $urandom_range(1, 14);
            rd(1'b1);
            repeat (count - 1) rd(1'($urandom_range(0, 1)));
         end else if (pick < 84) begin
            push_req(OP_WRITE, byte_type'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
         end else if (pick < 91) begin
            // noise over every op and byte value
            count = $urandom_range(1, 6);
            repeat (count)
               push_req(OP_W'($urandom_range(0, 3)), byte_type'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
         end else if (pick < 97 || fill_done) begin
            // unterminated line, sometimes killed
            count = $urandom_range(1, 8);
            repeat (count) key(byte_type'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 1) == 0) key(CHAR_CTLU);
         end else begin
            // overfill the ring once, then drain it
            fill_done = 1'b1;
            repeat (FILL_LENGTH) key(byte_type'($urandom_range(8'h20, 8'h7E)));
            rd(1'b1);
            repeat (FILL_LENGTH) rd(1'($urandom_range(0, 1)));
         end
      end

      // drain
      req_chan.valid = 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("ran %0d random beats after the directed set: %0d lines committed, %0d bytes read",
               useful_sent, lines_done, reads_done);
      $display("%0d end-of-file reads, %0d ring-full events, one %0d-cycle receiver hold",
               eofs_done, full_hits, HOLD_CYCLES);
      if (mismatches == 0 && awaiting == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
